// File: rtl/multi_type_elementwise_adder_macros.svh
// Assertion helpers for the RTL
`ifndef MULTI_TYPE_ELEMENTWISE_ADDER_MACROS_SVH
`define MULTI_TYPE_ELEMENTWISE_ADDER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define MTEA_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define MTEA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/mtea_pkg.sv
package mtea_pkg;

    localparam int unsigned DATA_W  = 64;
    localparam int unsigned TYPE_W  = 3;

    // Float format geometry
    localparam int unsigned F32_EBITS = 8;
    localparam int unsigned F32_MBITS = 23;
    localparam int unsigned F64_EBITS = 11;
    localparam int unsigned F64_MBITS = 52;
    localparam int unsigned F16_EBITS = 5;
    localparam int unsigned F16_MBITS = 10;

    // Element type codes
    localparam logic [TYPE_W-1:0] TYPE_F32   = 3'd0;
    localparam logic [TYPE_W-1:0] TYPE_F64   = 3'd1;
    localparam logic [TYPE_W-1:0] TYPE_F16   = 3'd2;
    localparam logic [TYPE_W-1:0] TYPE_UINT8 = 3'd3;
    localparam logic [TYPE_W-1:0] TYPE_INT32 = 3'd4;
    localparam logic [TYPE_W-1:0] TYPE_INT8  = 3'd5;
    localparam logic [TYPE_W-1:0] TYPE_INT64 = 3'd6;

    typedef struct packed {
        logic [DATA_W-1:0] operand_a;
        logic [DATA_W-1:0] operand_b;
        logic              last_in;
    } in_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] sum_bits;
        logic              last_out;
    } out_item_t;

endpackage

// File: rtl/multi_type_elementwise_adder.sv
// Elementwise adder for gradient reduction. Each item carries two operands and
// yields their sum in the format set by element_type (binary32, binary64,
// binary16 with round to nearest even, or wrapping uint8, int8, int32, int64),
// with the last marker copied through. The block is a two-register pipeline:
// an item is accepted every cycle while s_ready is high and is captured in the
// input register; the whole add sits between the input and result registers,
// and m_valid is driven from the result register. A stalled result backs up
// through both registers before s_ready drops. Write element_type only while no
// item is in flight.
`include "multi_type_elementwise_adder_macros.svh"

module multi_type_elementwise_adder (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [mtea_pkg::TYPE_W-1:0]         cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  mtea_pkg::in_item_t                  s_item,
    output logic                                m_valid,
    input  logic                                m_ready,
    output mtea_pkg::out_item_t                 m_item
);

    localparam int unsigned W32 = mtea_pkg::F32_EBITS + mtea_pkg::F32_MBITS + 1;
    localparam int unsigned W64 = mtea_pkg::F64_EBITS + mtea_pkg::F64_MBITS + 1;
    localparam int unsigned W16 = mtea_pkg::F16_EBITS + mtea_pkg::F16_MBITS + 1;

    logic [mtea_pkg::TYPE_W-1:0] element_type_reg;
    mtea_pkg::in_item_t          in_reg;
    logic                        in_valid_reg;
    mtea_pkg::out_item_t         out_reg, out_next;
    logic                        out_valid_reg;
    logic                        adv_out;
    logic [W32-1:0]              sum32;
    logic [W64-1:0]              sum64;
    logic [W16-1:0]              sum16;
    logic [mtea_pkg::DATA_W-1:0] int_sum;

    // Advance the result stage when it is empty or being drained
    assign adv_out = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || adv_out;
    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

    // Hold the element type register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            element_type_reg <= mtea_pkg::TYPE_F32;
        end else if (cfg_wr_en) begin
            element_type_reg <= cfg_wr_data;
        end
    end

    mtea_fp_add #(.EBITS(mtea_pkg::F32_EBITS), .MBITS(mtea_pkg::F32_MBITS)) u_add32 (
        .a   (in_reg.operand_a[W32-1:0]),
        .b   (in_reg.operand_b[W32-1:0]),
        .sum (sum32)
    );

    mtea_fp_add #(.EBITS(mtea_pkg::F64_EBITS), .MBITS(mtea_pkg::F64_MBITS)) u_add64 (
        .a   (in_reg.operand_a[W64-1:0]),
        .b   (in_reg.operand_b[W64-1:0]),
        .sum (sum64)
    );

    mtea_fp_add #(.EBITS(mtea_pkg::F16_EBITS), .MBITS(mtea_pkg::F16_MBITS)) u_add16 (
        .a   (in_reg.operand_a[W16-1:0]),
        .b   (in_reg.operand_b[W16-1:0]),
        .sum (sum16)
    );

    // Select the sum for the configured element type
    always_comb begin
        int_sum = in_reg.operand_a + in_reg.operand_b;
        out_next.last_out = in_reg.last_in;
        case (element_type_reg)
            mtea_pkg::TYPE_F32:   out_next.sum_bits = mtea_pkg::DATA_W'(sum32);
            mtea_pkg::TYPE_F64:   out_next.sum_bits = mtea_pkg::DATA_W'(sum64);
            mtea_pkg::TYPE_F16:   out_next.sum_bits = mtea_pkg::DATA_W'(sum16);
            mtea_pkg::TYPE_UINT8,
            mtea_pkg::TYPE_INT8:  out_next.sum_bits = mtea_pkg::DATA_W'(int_sum[7:0]);
            mtea_pkg::TYPE_INT32: out_next.sum_bits = mtea_pkg::DATA_W'(int_sum[31:0]);
            mtea_pkg::TYPE_INT64: out_next.sum_bits = int_sum;
            default:              out_next.sum_bits = '0;
        endcase
    end

    // Advance the input and result stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (adv_out) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_item;
        end
        if (adv_out && in_valid_reg) begin
            out_reg <= out_next;
        end
    end

    `MTEA_ASSERT_NEXT(a_item_moves_on, aclk, aresetn, in_valid_reg && adv_out, out_valid_reg)
    `MTEA_ASSERT_SAME(a_ready_low_full, aclk, aresetn, !s_ready, in_valid_reg && out_valid_reg)
    `MTEA_ASSERT_NEXT(a_stall_holds, aclk, aresetn, out_valid_reg && !m_ready, out_valid_reg && $stable(out_reg))

endmodule

// File: rtl/mtea_fp_add.sv
module mtea_fp_add #(
    parameter int unsigned EBITS = mtea_pkg::F32_EBITS,
    parameter int unsigned MBITS = mtea_pkg::F32_MBITS
) (
    input  logic [EBITS+MBITS:0] a,
    input  logic [EBITS+MBITS:0] b,
    output logic [EBITS+MBITS:0] sum
);

    localparam int unsigned W  = EBITS + MBITS + 1;
    localparam int unsigned SW = MBITS + 4;
    localparam int unsigned RW = MBITS + 5;
    localparam int unsigned QW = MBITS + 2;
    localparam int unsigned EW = EBITS + 1;

    localparam logic [EBITS-1:0] EMAX = {EBITS{1'b1}};
    localparam logic [W-1:0] QNAN = {1'b0, EMAX, 1'b1, {(MBITS-1){1'b0}}};

    logic             sa, sb, s_l, s_s;
    logic [EBITS-1:0] ea, eb, xa, xb, x_l, x_s, d, ef;
    logic [MBITS-1:0] fa, fb;
    logic [SW-1:0]    siga, sigb, sig_l, sig_s, sig_al, lost_mask;
    logic             swap;
    logic [RW-1:0]    r, r_n;
    logic [EW-1:0]    e, e_n, e_f, lz, msb, sh, e_m1;
    logic [QW-1:0]    q, q_r, q_f;
    logic [2:0]       rem;
    logic             inc;

    always_comb begin
        sa = a[W-1];
        sb = b[W-1];
        ea = a[W-2:MBITS];
        eb = b[W-2:MBITS];
        fa = a[MBITS-1:0];
        fb = b[MBITS-1:0];
        siga = {(ea != '0), fa, 3'b000};
        sigb = {(eb != '0), fb, 3'b000};
        xa = (ea != '0) ? ea : EBITS'(1);
        xb = (eb != '0) ? eb : EBITS'(1);

        // Order operands so the larger magnitude comes first
        swap  = (xb > xa) || ((xb == xa) && (sigb > siga));
        s_l   = swap ? sb : sa;
        s_s   = swap ? sa : sb;
        x_l   = swap ? xb : xa;
        x_s   = swap ? xa : xb;
        sig_l = swap ? sigb : siga;
        sig_s = swap ? siga : sigb;

        // Align the smaller operand, folding lost bits into a sticky bit
        d = x_l - x_s;
        lost_mask = ~({SW{1'b1}} << d);
        if ({1'b0, d} >= EW'(MBITS + 5)) begin
            sig_al = SW'(sig_s != '0);
        end else begin
            sig_al = (sig_s >> d) | SW'((sig_s & lost_mask) != '0);
        end

        r = (s_l == s_s) ? ({1'b0, sig_l} + {1'b0, sig_al})
                         : ({1'b0, sig_l} - {1'b0, sig_al});
        e = {1'b0, x_l};

        // Find the leading one below the carry bit
        msb = '0;
        for (int i = 0; i < RW - 1; i++) begin
            if (r[i]) begin
                msb = EW'(i);
            end
        end
        lz   = EW'(RW - 2) - msb;
        e_m1 = e - EW'(1);
        sh   = (lz < e_m1) ? lz : e_m1;

        // Normalise: right by one on carry, else left within exponent range
        if (r[RW-1]) begin
            r_n = (r >> 1) | RW'(r[0]);
            e_n = e + EW'(1);
        end else begin
            r_n = r << sh;
            e_n = e - sh;
        end

        // Round to nearest, ties to even
        q   = r_n[RW-1:3];
        rem = r_n[2:0];
        inc = (rem > 3'd4) || ((rem == 3'd4) && q[0]);
        q_r = q + QW'(inc);
        if (q_r[QW-1]) begin
            q_f = q_r >> 1;
            e_f = e_n + EW'(1);
        end else begin
            q_f = q_r;
            e_f = e_n;
        end
        ef = q_f[MBITS] ? e_f[EBITS-1:0] : '0;

        // Resolve special operands and results
        if (((ea == EMAX) && (fa != '0)) || ((eb == EMAX) && (fb != '0))) begin
            sum = QNAN;
        end else if (ea == EMAX) begin
            sum = ((eb == EMAX) && (sa != sb)) ? QNAN : a;
        end else if (eb == EMAX) begin
            sum = b;
        end else if (r == '0) begin
            sum = {(s_l & s_s), {(W-1){1'b0}}};
        end else if (e_f >= {1'b0, EMAX}) begin
            sum = {s_l, EMAX, {MBITS{1'b0}}};
        end else begin
            sum = {s_l, ef, q_f[MBITS-1:0]};
        end
    end

endmodule
